/* hdl/ibfr_pkg.sv */
// Package for the serial servo-link frame receiver.
// Holds the shared widths, header and checksum constants, and the word transfer struct.
// No dependencies.
package ibfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 16;
    localparam int IDX_W        = 4;
    localparam int CHANNELS_DEF = 14;
    localparam int CHANNELS_MAX = 14;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h20;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h40;
    localparam logic [WORD_W-1:0] SUM_INIT   = 16'hFFFF;

    // Parser to cell chain: one finished channel word, or the end of a good frame.
    typedef struct packed {
        logic              push;
        logic [WORD_W-1:0] word;
        logic              good;
    } t_push;

endpackage

/* hdl/ibfr_cell.sv */
// One cell of the channel chain: holds one 16-bit channel word.
// Loads i_data, from its neighbor or from the parser word, on a shift. Depends on ibfr_pkg.
module ibfr_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [ibfr_pkg::WORD_W-1:0] i_data,
    output logic [ibfr_pkg::WORD_W-1:0] o_data
);
    import ibfr_pkg::*;

    logic [WORD_W-1:0] r_value;

    // Payload register; it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_data;
        end
    end

    assign o_data = r_value;

endmodule

/* hdl/ibfr_parser.sv */
// Frame parser: header hunt, running checksum, channel word assembly.
// Depends on ibfr_pkg.
module ibfr_parser #(
    parameter int CHANNELS = ibfr_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [ibfr_pkg::BYTE_W-1:0] i_rx_byte,
    output ibfr_pkg::t_push             o_push
);
    import ibfr_pkg::*;

    localparam int FRAME_LEN = 2 * CHANNELS + 4;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SECOND   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA_END = POS_W'(2 + 2 * CHANNELS);
    localparam logic [POS_W-1:0] POS_CHK_LOW  = POS_W'(2 + 2 * CHANNELS);
    localparam logic [POS_W-1:0] POS_CHK_HIGH = POS_W'(3 + 2 * CHANNELS);

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [WORD_W-1:0] r_sum,  n_sum;
    logic [BYTE_W-1:0] r_low,  n_low;
    logic [BYTE_W-1:0] r_chk,  n_chk;
    logic              s_in_data;

    assign s_in_data = (r_pos >= POS_W'(2)) && (r_pos < POS_DATA_END);

    // Next-state logic for one accepted byte.
    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_low  = r_low;
        n_chk  = r_chk;
        o_push = '0;
        o_push.word = {i_rx_byte, r_low};
        if (i_accept) begin
            if (r_pos == POS_HUNT) begin
                if (i_rx_byte == HDR_FIRST) begin
                    n_sum = SUM_INIT - WORD_W'(HDR_FIRST);
                    n_pos = POS_SECOND;
                end
            end else if (r_pos == POS_SECOND) begin
                if (i_rx_byte == HDR_SECOND) begin
                    n_sum = r_sum - WORD_W'(i_rx_byte);
                    n_pos = POS_W'(2);
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (s_in_data) begin
                // Even positions carry the low byte, odd ones finish the word.
                n_sum = r_sum - WORD_W'(i_rx_byte);
                if (!r_pos[0]) begin
                    n_low = i_rx_byte;
                end else begin
                    o_push.push = 1'b1;
                end
                n_pos = r_pos + POS_W'(1);
            end else if (r_pos == POS_CHK_LOW) begin
                n_chk = i_rx_byte;
                n_pos = r_pos + POS_W'(1);
            end else if (r_pos == POS_CHK_HIGH) begin
                o_push.good = ({i_rx_byte, r_chk} == r_sum);
                n_pos = POS_HUNT;
                n_sum = SUM_INIT;
            end else begin
                n_pos = POS_HUNT;
                n_sum = SUM_INIT;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= SUM_INIT;
            r_low <= '0;
            r_chk <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_low <= n_low;
            r_chk <= n_chk;
        end
    end

endmodule

/* hdl/ibus_frame_receiver.sv */
// Latency: the first channel transaction is offered the cycle after the last checksum byte.
// Throughput: one byte per cycle while a frame arrives; after a good frame the cell chain
// drains one channel per cycle while i_stall is low, input stalled meanwhile.
// The drain rate is set by the chain shifting one cell per output transaction.
// Reset (synchronous, active low) returns to the header hunt, sets the checksum to 0xFFFF
// and drops any pending output; the channel cells are not cleared.
module ibus_frame_receiver #(
    parameter int CHANNELS = ibfr_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ibfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ibfr_pkg::IDX_W-1:0]  o_channel_index,
    output logic [ibfr_pkg::WORD_W-1:0] o_channel_value,
    output logic                        o_last_channel
);
    import ibfr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    t_push             s_push;
    logic              s_accept;
    logic              s_take;
    logic              s_shift;
    logic [WORD_W-1:0] s_cell [CHANNELS];
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;

    assign s_accept = i_valid && !o_stall;
    assign s_take   = o_valid && !i_stall;
    assign s_shift  = s_push.push || s_take;

    ibfr_parser #(
        .CHANNELS (CHANNELS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (s_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (s_push)
    );

    // Chain of cells: words enter at the tail and leave at the head.
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chain
        if (g == CHANNELS - 1) begin : g_tail
            ibfr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (s_shift),
                .i_data  (s_push.word),
                .o_data  (s_cell[g])
            );
        end else begin : g_body
            ibfr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (s_shift),
                .i_data  (s_cell[g+1]),
                .o_data  (s_cell[g])
            );
        end
    end

    // Emission control: one channel transaction per cycle after a good frame, unless i_stall holds it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (s_push.good) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (s_take) begin
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign o_stall         = r_busy;
    assign o_valid         = r_busy;
    assign o_channel_index = r_idx;
    assign o_channel_value = s_cell[0];
    assign o_last_channel  = (r_idx == LAST_IDX);

`ifndef SYNTH
    // A frame can only complete while the chain is not draining.
    a_good_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push.good |-> !r_busy)
        else $error("frame completed during emission");

    // No word enters the chain while it drains.
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_push.push)
        else $error("word pushed during emission");

    // Taking the last channel ends the emission.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_take && o_last_channel) |=> !o_valid)
        else $error("emission ran past the last channel");

    // The channel index never goes beyond the last channel.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx <= LAST_IDX))
        else $error("channel index out of range");
`endif

endmodule
